>>> design/irrs_pkg.sv
// ----------------------------------------------------------------------------
// irrs_pkg
// Types, codes and sizes shared by the retry scheduler files.
// ----------------------------------------------------------------------------
package irrs_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PEER_COUNT    = 32;

    localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
    localparam int PEER_W     = $clog2(PEER_COUNT);
    localparam int CUR_W      = PEER_W + 1;
    localparam int KEY_W      = 64;
    localparam int TIME_W     = 48;
    localparam int NODE_W     = 5;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [SLOT_W:0]       scan_cnt_t;
    typedef logic [PEER_W-1:0]     peer_idx_t;
    typedef logic [CUR_W-1:0]      cur_t;
    typedef logic [PEER_COUNT-1:0] mask_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [TIME_W-1:0]     time_t;
    typedef logic [TIME_W:0]       time_sum_t;
    typedef logic [NODE_W-1:0]     node_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // request type codes
    localparam logic [2:0] REQ_ANNOUNCE  = 3'd0;
    localparam logic [2:0] REQ_COMPLETED = 3'd1;
    localparam logic [2:0] REQ_LEAVE     = 3'd2;
    localparam logic [2:0] REQ_JOIN      = 3'd3;
    localparam logic [2:0] REQ_TICK      = 3'd4;

    // result event codes
    localparam logic [1:0] EV_SENT    = 2'd0;
    localparam logic [1:0] EV_DISCARD = 2'd1;
    localparam logic [1:0] EV_FULL    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 1'b1;

    localparam cur_t  NO_PEER   = cur_t'(PEER_COUNT);
    localparam cnt_t  CNT_MAX   = '1;
    localparam time_t TIME_MAX  = '1;
    localparam slot_t LAST_SLOT = slot_t'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [2:0]        req_type;
        logic [NODE_W-1:0] node_id;
        logic [KEY_W-1:0]  item_key;
        logic [TIME_W-1:0] now_time;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [KEY_W-1:0]  out_key;
        logic [NODE_W-1:0] out_node;
        logic              is_retry;
        logic              last;
    } res_item_t;

    // one table slot as held in the entry RAM
    typedef struct packed {
        key_t  key;
        mask_t holder;
        mask_t untried;
        cur_t  cur;
        time_t due;
        logic  imm;
    } entry_rec_t;

    localparam int ENTRY_W = $bits(entry_rec_t);

    // lowest set bit of a peer mask
    function automatic peer_idx_t lowest_peer(mask_t m);
        peer_idx_t p;
        p = '0;
        for (int i = PEER_COUNT - 1; i >= 0; i--) begin
            if (m[i])
            begin
                p = peer_idx_t'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> design/irrs_ram.sv
// ----------------------------------------------------------------------------
// irrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/item_request_retry_scheduler_unit.sv
// ----------------------------------------------------------------------------
// item_request_retry_scheduler_unit
// Table of outstanding item requests with per-peer retry scheduling.
// ----------------------------------------------------------------------------
// One item at a time is taken while busy is low. A join is handled without
// leaving idle. An accepted announce, any completion or a leave by a joined
// peer sweeps the entry RAM once at one slot per cycle. A tick sweeps the RAM
// once per due entry to find the earliest, plus one final sweep. The entry RAM
// has a single read port. Results come out as one-cycle strobes on result_valid
// and cannot be held off; a tick result is held back one round so that last
// can be marked.
// ----------------------------------------------------------------------------
module item_request_retry_scheduler_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  irrs_pkg::req_item_t                 req,
    output logic                                result_valid,
    output irrs_pkg::res_item_t                 result,
    input  logic                                cfg_we,
    input  logic [irrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_POST} state_t;

    state_t               state_reg, state_next;
    irrs_pkg::req_item_t  op_reg, op_next;
    logic [31:0]          timeout_reg, timeout_next;
    irrs_pkg::cnt_t       max_reg, max_next;

    logic                 valid_reg  [irrs_pkg::TABLE_ENTRIES];
    logic                 valid_next [irrs_pkg::TABLE_ENTRIES];
    logic                 done_reg   [irrs_pkg::TABLE_ENTRIES];
    logic                 done_next  [irrs_pkg::TABLE_ENTRIES];
    irrs_pkg::cnt_t       cnt_reg    [irrs_pkg::PEER_COUNT];
    irrs_pkg::cnt_t       cnt_next   [irrs_pkg::PEER_COUNT];
    logic                 joined_reg [irrs_pkg::PEER_COUNT];
    logic                 joined_next[irrs_pkg::PEER_COUNT];

    irrs_pkg::scan_cnt_t  iss_reg, iss_next;
    logic                 chk_vld_reg, chk_vld_next;
    irrs_pkg::slot_t      chk_slot_reg, chk_slot_next;
    logic                 hit_reg, hit_next;
    irrs_pkg::slot_t      hit_slot_reg, hit_slot_next;
    irrs_pkg::entry_rec_t hit_rec_reg, hit_rec_next;
    irrs_pkg::time_t      best_t_reg, best_t_next;
    logic                 free_reg, free_next;
    irrs_pkg::slot_t      free_slot_reg, free_slot_next;
    irrs_pkg::res_item_t  pend_reg, pend_next;
    logic                 pend_vld_reg, pend_vld_next;
    irrs_pkg::res_item_t  res_reg, res_next;
    logic                 res_vld_reg, res_vld_next;

    // entry RAM ports
    logic                 ram_we;
    irrs_pkg::slot_t      ram_waddr;
    irrs_pkg::entry_rec_t ram_wdata;
    irrs_pkg::entry_rec_t ram_rdata;

    // decode helpers
    irrs_pkg::peer_idx_t  in_pidx, op_pidx, send_pidx;
    logic                 in_node_ok;
    irrs_pkg::mask_t      op_bit;
    irrs_pkg::time_t      ent_due;
    irrs_pkg::time_sum_t  retry_sum;
    irrs_pkg::time_t      retry_due;
    irrs_pkg::entry_rec_t rec_mod;
    irrs_pkg::res_item_t  new_res;

    irrs_ram #(
        .WIDTH(irrs_pkg::ENTRY_W),
        .DEPTH(irrs_pkg::TABLE_ENTRIES)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(iss_reg[irrs_pkg::SLOT_W-1:0]),
        .rdata(ram_rdata)
    );

    assign in_pidx    = irrs_pkg::peer_idx_t'(req.node_id);
    assign op_pidx    = irrs_pkg::peer_idx_t'(op_reg.node_id);
    assign in_node_ok = 32'(req.node_id) < irrs_pkg::PEER_COUNT;
    assign op_bit     = irrs_pkg::mask_t'(1) << op_pidx;
    assign ent_due    = ram_rdata.imm ? '0 : ram_rdata.due;
    assign retry_sum  = {1'b0, op_reg.now_time} + irrs_pkg::time_sum_t'(timeout_reg);
    assign retry_due  = retry_sum[irrs_pkg::TIME_W] ? irrs_pkg::TIME_MAX
                                                    : retry_sum[irrs_pkg::TIME_W-1:0];
    assign send_pidx  = irrs_pkg::lowest_peer(hit_rec_reg.untried);

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        timeout_next   = timeout_reg;
        max_next       = max_reg;
        valid_next     = valid_reg;
        done_next      = done_reg;
        cnt_next       = cnt_reg;
        joined_next    = joined_reg;
        iss_next       = iss_reg;
        chk_vld_next   = 1'b0;
        chk_slot_next  = chk_slot_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_rec_next   = hit_rec_reg;
        best_t_next    = best_t_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        res_next       = res_reg;
        res_vld_next   = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = chk_slot_reg;
        ram_wdata      = ram_rdata;
        rec_mod        = ram_rdata;
        new_res        = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                irrs_pkg::CFG_TIMEOUT: timeout_next = cfg_data;
                irrs_pkg::CFG_MAX:     max_next     = irrs_pkg::cnt_t'(cfg_data);
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                iss_next  = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                if (start)
                begin
                    op_next = req;
                    priority if (req.req_type == irrs_pkg::REQ_TICK)
                    begin
                        for (int s = 0; s < irrs_pkg::TABLE_ENTRIES; s++)
                        begin
                            done_next[s] = 1'b0;
                        end
                        pend_vld_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                    else if (req.req_type == irrs_pkg::REQ_COMPLETED)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (!in_node_ok)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (req.req_type == irrs_pkg::REQ_ANNOUNCE)
                    begin
                        if (joined_reg[in_pidx] && cnt_reg[in_pidx] <= max_reg)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (req.req_type == irrs_pkg::REQ_LEAVE)
                    begin
                        if (joined_reg[in_pidx])
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (req.req_type == irrs_pkg::REQ_JOIN)
                    begin
                        joined_next[in_pidx] = 1'b1;
                    end
                    else
                    begin
                        // unknown request type: taken and dropped
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, check the slot read last cycle
                if (32'(iss_reg) < irrs_pkg::TABLE_ENTRIES)
                begin
                    iss_next      = iss_reg + 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_slot_next = iss_reg[irrs_pkg::SLOT_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    priority case (op_reg.req_type)
                        irrs_pkg::REQ_TICK:
                        begin
                            if (valid_reg[chk_slot_reg] && !done_reg[chk_slot_reg] &&
                                ent_due <= op_reg.now_time &&
                                (!hit_reg || ent_due < best_t_reg))
                            begin
                                hit_next      = 1'b1;
                                hit_slot_next = chk_slot_reg;
                                hit_rec_next  = ram_rdata;
                                best_t_next   = ent_due;
                            end
                        end
                        irrs_pkg::REQ_LEAVE:
                        begin
                            if (valid_reg[chk_slot_reg] && ram_rdata.holder[op_pidx])
                            begin
                                rec_mod.holder  = ram_rdata.holder & ~op_bit;
                                rec_mod.untried = ram_rdata.untried & ~op_bit;
                                if (ram_rdata.cur == irrs_pkg::cur_t'(op_pidx))
                                begin
                                    rec_mod.cur = irrs_pkg::NO_PEER;
                                    rec_mod.imm = 1'b1;
                                    rec_mod.due = '0;
                                end
                                ram_we    = 1'b1;
                                ram_wdata = rec_mod;
                            end
                        end
                        default:
                        begin
                            // announce and completed: key lookup, first free slot
                            if (valid_reg[chk_slot_reg])
                            begin
                                if (!hit_reg && ram_rdata.key == op_reg.item_key)
                                begin
                                    hit_next      = 1'b1;
                                    hit_slot_next = chk_slot_reg;
                                    hit_rec_next  = ram_rdata;
                                end
                            end
                            else if (!free_reg)
                            begin
                                free_next      = 1'b1;
                                free_slot_next = chk_slot_reg;
                            end
                        end
                    endcase
                    if (chk_slot_reg == irrs_pkg::LAST_SLOT)
                    begin
                        state_next = ST_POST;
                    end
                end
            end

            ST_POST:
            begin
                state_next = ST_IDLE;
                ram_waddr  = hit_slot_reg;
                rec_mod    = hit_rec_reg;
                priority case (op_reg.req_type)
                    irrs_pkg::REQ_ANNOUNCE:
                    begin
                        if (hit_reg)
                        begin
                            if (!hit_rec_reg.holder[op_pidx])
                            begin
                                rec_mod.holder  = hit_rec_reg.holder | op_bit;
                                rec_mod.untried = hit_rec_reg.untried | op_bit;
                                ram_we          = 1'b1;
                                ram_wdata       = rec_mod;
                                if (cnt_reg[op_pidx] != irrs_pkg::CNT_MAX)
                                begin
                                    cnt_next[op_pidx] = cnt_reg[op_pidx] + 1'b1;
                                end
                            end
                        end
                        else if (free_reg)
                        begin
                            ram_waddr         = free_slot_reg;
                            ram_we            = 1'b1;
                            ram_wdata.key     = op_reg.item_key;
                            ram_wdata.holder  = op_bit;
                            ram_wdata.untried = op_bit;
                            ram_wdata.cur     = irrs_pkg::NO_PEER;
                            ram_wdata.due     = '0;
                            ram_wdata.imm     = 1'b1;
                            valid_next[free_slot_reg] = 1'b1;
                            if (cnt_reg[op_pidx] != irrs_pkg::CNT_MAX)
                            begin
                                cnt_next[op_pidx] = cnt_reg[op_pidx] + 1'b1;
                            end
                        end
                        else
                        begin
                            res_vld_next       = 1'b1;
                            res_next           = '0;
                            res_next.event_res = irrs_pkg::EV_FULL;
                            res_next.out_key   = op_reg.item_key;
                            res_next.last      = 1'b1;
                        end
                    end
                    irrs_pkg::REQ_COMPLETED:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[hit_slot_reg] = 1'b0;
                            for (int p = 0; p < irrs_pkg::PEER_COUNT; p++)
                            begin
                                if (hit_rec_reg.holder[p] && cnt_reg[p] != '0)
                                begin
                                    cnt_next[p] = cnt_reg[p] - 1'b1;
                                end
                            end
                        end
                    end
                    irrs_pkg::REQ_LEAVE:
                    begin
                        joined_next[op_pidx] = 1'b0;
                        cnt_next[op_pidx]    = '0;
                    end
                    default:
                    begin
                        // tick: handle the earliest due entry and sweep again, or finish when none is due
                        if (hit_reg)
                        begin
                            done_next[hit_slot_reg] = 1'b1;
                            new_res.out_key = hit_rec_reg.key;
                            if (hit_rec_reg.untried == '0)
                            begin
                                new_res.event_res = irrs_pkg::EV_DISCARD;
                                valid_next[hit_slot_reg] = 1'b0;
                                for (int p = 0; p < irrs_pkg::PEER_COUNT; p++)
                                begin
                                    if (hit_rec_reg.holder[p] && cnt_reg[p] != '0)
                                    begin
                                        cnt_next[p] = cnt_reg[p] - 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                new_res.event_res = irrs_pkg::EV_SENT;
                                new_res.out_node  = irrs_pkg::node_t'(send_pidx);
                                new_res.is_retry  = !hit_rec_reg.imm;
                                rec_mod.untried   = hit_rec_reg.untried &
                                                    ~(irrs_pkg::mask_t'(1) << send_pidx);
                                rec_mod.cur       = irrs_pkg::cur_t'(send_pidx);
                                rec_mod.due       = retry_due;
                                rec_mod.imm       = 1'b0;
                                ram_we            = 1'b1;
                                ram_wdata         = rec_mod;
                            end
                            if (pend_vld_reg)
                            begin
                                res_vld_next = 1'b1;
                                res_next     = pend_reg;
                            end
                            pend_next     = new_res;
                            pend_vld_next = 1'b1;
                            iss_next      = '0;
                            hit_next      = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        else
                        begin
                            if (pend_vld_reg)
                            begin
                                res_vld_next  = 1'b1;
                                res_next      = pend_reg;
                                res_next.last = 1'b1;
                            end
                            pend_vld_next = 1'b0;
                        end
                    end
                endcase
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            timeout_reg  <= 32'd60000000;
            max_reg      <= irrs_pkg::cnt_t'(63);
            iss_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            for (int s = 0; s < irrs_pkg::TABLE_ENTRIES; s++)
            begin
                valid_reg[s] <= 1'b0;
                done_reg[s]  <= 1'b0;
            end
            for (int p = 0; p < irrs_pkg::PEER_COUNT; p++)
            begin
                cnt_reg[p]    <= '0;
                joined_reg[p] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            timeout_reg  <= timeout_next;
            max_reg      <= max_next;
            iss_reg      <= iss_next;
            chk_vld_reg  <= chk_vld_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
            cnt_reg      <= cnt_next;
            joined_reg   <= joined_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        chk_slot_reg  <= chk_slot_next;
        hit_slot_reg  <= hit_slot_next;
        hit_rec_reg   <= hit_rec_next;
        best_t_reg    <= best_t_next;
        free_slot_reg <= free_slot_next;
        pend_reg      <= pend_next;
        res_reg       <= res_next;
    end

    // final result of an item is never followed directly by another
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result right after a final result");

    // only sent requests name a peer or carry the retry flag
    a_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_res != irrs_pkg::EV_SENT |->
            result.out_node == '0 && !result.is_retry)
        else $error("peer or retry on a non-request result");

    // a join is handled in the accepting cycle
    a_join_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == irrs_pkg::REQ_JOIN |=> !busy)
        else $error("join left the block busy");

    // a full-table report comes only from an announce
    a_full_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_res == irrs_pkg::EV_FULL |->
            op_reg.req_type == irrs_pkg::REQ_ANNOUNCE && result.last)
        else $error("full-table result outside an announce");

endmodule

>>> sim/irrs_checker.sv
// ----------------------------------------------------------------------------
// irrs_checker
// Watches the request and result channels of the retry scheduler, keeps its
// own copy of the request table, predicts each result and compares.
// ----------------------------------------------------------------------------
module irrs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  irrs_pkg::req_item_t                 req,
    input  logic                                result_valid,
    input  irrs_pkg::res_item_t                 result,
    input  logic                                cfg_we,
    input  logic [irrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irrs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output logic                                progress
);
    timeunit 1ns;
    timeprecision 1ps;
    import irrs_pkg::*;

    logic [31:0] timeout_ticks;
    cnt_t        node_cap;
    logic        slot_used [TABLE_ENTRIES];
    key_t        slot_key [TABLE_ENTRIES];
    mask_t       slot_holders [TABLE_ENTRIES];
    mask_t       slot_untried [TABLE_ENTRIES];
    cur_t        slot_peer [TABLE_ENTRIES];
    time_t       slot_due [TABLE_ENTRIES];
    logic        slot_now [TABLE_ENTRIES];
    cnt_t        peer_items [PEER_COUNT];
    logic        peer_in [PEER_COUNT];
    res_item_t   expected_events [$];

    function automatic void release_slot(int s);
        for (int p = 0; p < PEER_COUNT; p++)
            if (slot_holders[s][p] && peer_items[p] != 0)
                peer_items[p]--;
        slot_used[s] = 1'b0;
    endfunction

    function automatic int slot_of(key_t k);
        for (int s = 0; s < TABLE_ENTRIES; s++)
            if (slot_used[s] && slot_key[s] == k)
                return s;
        return -1;
    endfunction

    function automatic void push_event(logic [1:0] ev, key_t k, node_t n, logic rt);
        res_item_t r;
        r.event_res = ev;
        r.out_key   = k;
        r.out_node  = n;
        r.is_retry  = rt;
        r.last      = 1'b0;
        expected_events.push_back(r);
    endfunction

    function automatic void apply_request(req_item_t q);
        int s;
        int best;
        int cnt;
        logic handled [TABLE_ENTRIES];
        time_t bt;
        time_t t;
        logic [48:0] sum;
        peer_idx_t p;
        node_t n;
        n = q.node_id;
        cnt = 0;
        if (q.req_type == REQ_TICK) begin
            foreach (handled[i]) handled[i] = 1'b0;
            forever begin
                best = -1;
                bt = '0;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!slot_used[i] || handled[i]) continue;
                    t = slot_now[i] ? time_t'(0) : slot_due[i];
                    if (t > q.now_time) continue;
                    if (best < 0 || t < bt) begin
                        best = i;
                        bt = t;
                    end
                end
                if (best < 0) break;
                handled[best] = 1'b1;
                cnt++;
                if (slot_untried[best] == '0) begin
                    push_event(EV_DISCARD, slot_key[best], '0, 1'b0);
                    release_slot(best);
                    continue;
                end
                p = '0;
                for (int i = PEER_COUNT - 1; i >= 0; i--)
                    if (slot_untried[best][i]) p = peer_idx_t'(i);
                slot_untried[best][p] = 1'b0;
                slot_peer[best] = cur_t'(p);
                push_event(EV_SENT, slot_key[best], node_t'(p), !slot_now[best]);
                sum = {1'b0, q.now_time} + 49'(timeout_ticks);
                slot_due[best] = sum[48] ? TIME_MAX : sum[47:0];
                slot_now[best] = 1'b0;
            end
            if (cnt > 0) expected_events[$].last = 1'b1;
        end else if (q.req_type == REQ_COMPLETED) begin
            s = slot_of(q.item_key);
            if (s >= 0) release_slot(s);
        end else if (q.req_type == REQ_ANNOUNCE) begin
            if (!peer_in[n] || peer_items[n] > node_cap) return;
            s = slot_of(q.item_key);
            if (s < 0) begin
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    if (!slot_used[i]) s = i;
                if (s < 0) begin
                    push_event(EV_FULL, q.item_key, '0, 1'b0);
                    expected_events[$].last = 1'b1;
                    return;
                end
                slot_used[s] = 1'b1;
                slot_key[s] = q.item_key;
                slot_holders[s] = '0;
                slot_untried[s] = '0;
                slot_peer[s] = NO_PEER;
                slot_due[s] = '0;
                slot_now[s] = 1'b1;
            end
            if (!slot_holders[s][n]) begin
                slot_holders[s][n] = 1'b1;
                slot_untried[s][n] = 1'b1;
                if (peer_items[n] != CNT_MAX) peer_items[n]++;
            end
        end else if (q.req_type == REQ_LEAVE) begin
            if (!peer_in[n]) return;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!slot_used[i] || !slot_holders[i][n]) continue;
                slot_holders[i][n] = 1'b0;
                slot_untried[i][n] = 1'b0;
                if (slot_peer[i] == cur_t'(n)) begin
                    slot_peer[i] = NO_PEER;
                    slot_now[i] = 1'b1;
                    slot_due[i] = '0;
                end
            end
            peer_in[n] = 1'b0;
            peer_items[n] = '0;
        end else if (q.req_type == REQ_JOIN) begin
            peer_in[n] = 1'b1;
        end
    endfunction

    assign pending = expected_events.size();

    always @(posedge clk or negedge rst_n) begin
        res_item_t want;
        if (!rst_n) begin
            timeout_ticks <= 32'd60000000;
            node_cap      <= cnt_t'(63);
            for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] <= 1'b0;
            for (int i = 0; i < PEER_COUNT; i++) begin
                peer_items[i] <= '0;
                peer_in[i]    <= 1'b0;
            end
            expected_events.delete();
            fail_count <= 0;
            progress   <= 1'b0;
        end else begin
            progress <= (start && !busy) || result_valid;
            // results leave before the next transfer can add to the queue
            if (result_valid) begin
                if (expected_events.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %p", result);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_events.pop_front();
                    if (result !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_TIMEOUT) timeout_ticks = cfg_data;
                else if (cfg_index == CFG_MAX) node_cap = cnt_t'(cfg_data);
            end
            if (start && !busy)
                apply_request(req);
        end
    end
endmodule

>>> sim/tb_item_request_retry_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_item_request_retry_scheduler_unit
// Drives joins, leaves, announcements, completions and ticks into the retry
// scheduler across several register settings; the checker scores results.
// ----------------------------------------------------------------------------
module tb_item_request_retry_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import irrs_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    req_item_t             req = '0;
    logic                  result_valid;
    res_item_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    logic                  progress;
    int                    gap_pct = 0;
    int                    stall_cycles = 0;
    time_t                 clock_now = '0;
    key_t                  key_pool [8];

    // Limit: a tick holds its first result back one sweep, so the longest
    // stretch without a transfer is about two sweeps of the entry RAM.
    localparam int STALL_LIMIT = 20000;

    always #4 clk = ~clk;

    item_request_retry_scheduler_unit dut (.*);

    irrs_checker checker_i (.*);

    // watchdog: counts cycles in which nothing transfers on either channel
    always @(posedge clk) begin
        if (progress || !rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one transfer: optional random idle first, then hold start until accepted;
    // start stays high on return so a following item can go back to back
    task automatic send_req(logic [2:0] rt, node_t n, key_t k, time_t t);
        while ($urandom_range(99, 0) < gap_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        req   <= '{req_type: rt, node_id: n, item_key: k, now_time: t};
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // advance model time and tick
    task automatic tick_by(time_t d);
        clock_now = (clock_now > TIME_MAX - d) ? TIME_MAX : clock_now + d;
        send_req(REQ_TICK, node_t'($urandom), {$urandom, $urandom}, clock_now);
    endtask

    // wait out all expected results plus a full scan for silent work
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(int items);
        int r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99, 0);
            if (r < 35)
                send_req(REQ_ANNOUNCE, node_t'($urandom_range(7, 0)),
                         ($urandom_range(3, 0) == 0) ? {$urandom, $urandom}
                                                    : key_pool[$urandom_range(7, 0)],
                         time_t'({$urandom, $urandom}));
            else if (r < 45)
                send_req(REQ_COMPLETED, node_t'($urandom),
                         key_pool[$urandom_range(7, 0)], '0);
            else if (r < 55)
                send_req(REQ_LEAVE, node_t'($urandom_range(7, 0)), '0, '0);
            else if (r < 68)
                send_req(REQ_JOIN, node_t'($urandom_range(7, 0)), '0, '0);
            else if (r < 95)
                tick_by(time_t'($urandom_range(30, 0)));
            else
                send_req(3'($urandom_range(7, 5)), node_t'($urandom),
                         {$urandom, $urandom}, time_t'({$urandom, $urandom}));
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, default cap, timeout register set to 10
        write_reg(CFG_TIMEOUT, 32'd10);
        send_req(REQ_ANNOUNCE, 5'd1, key_pool[0], '0);     // peer not joined
        send_req(REQ_LEAVE, 5'd1, '0, '0);                 // leave not joined
        send_req(REQ_JOIN, 5'd0, '0, '0);
        send_req(REQ_JOIN, 5'd31, '0, '0);
        send_req(REQ_JOIN, 5'd31, '0, '0);                 // repeat join
        send_req(REQ_ANNOUNCE, 5'd31, key_pool[1], '1);
        send_req(REQ_ANNOUNCE, 5'd0, key_pool[1], '0);
        send_req(REQ_ANNOUNCE, 5'd0, key_pool[0], '0);
        send_req(REQ_COMPLETED, 5'd0, 64'h1234, '0);       // unknown item
        send_req(3'd7, 5'd0, key_pool[0], '0);             // unknown type
        send_req(3'd5, 5'd31, '1, '1);
        tick_by(0);                                        // immediate sends
        send_req(REQ_LEAVE, 5'd0, '0, '0);                 // retrigger
        tick_by(0);
        tick_by(20);                                       // retries, discards
        tick_by(20);
        tick_by(20);
        send_req(REQ_COMPLETED, 5'd0, key_pool[0], '0);
        drain();

        // fill the table, overflow it, then tick at the time ceiling
        write_reg(CFG_MAX, 32'd64);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_req(REQ_JOIN, 5'd2, '0, '0);
        for (int i = 0; i < 66; i++)
            send_req(REQ_ANNOUNCE, 5'd2, 64'(i) + 64'h100, '0);
        clock_now = TIME_MAX - 5;
        tick_by(1);
        drain();
        tick_by(TIME_MAX);
        drain();
        send_req(REQ_LEAVE, 5'd2, '0, '0);
        tick_by(1);
        drain();

        // random phases over several settings
        clock_now = '0;
        gap_pct = 27;
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_MAX, 32'd0);
        random_phase(120);
        drain();
        gap_pct = 55;
        write_reg(CFG_TIMEOUT, 32'd15);
        write_reg(CFG_MAX, 32'd3);
        random_phase(120);
        drain();
        gap_pct = 0;
        write_reg(CFG_TIMEOUT, 32'd40);
        write_reg(CFG_MAX, 32'd64);
        random_phase(120);
        tick_by(TIME_MAX);
        drain();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
